// ===== rtl/core/acfd_pkg.sv =====
// shared types and constants of the box face contact detector
package acfd_pkg;

  localparam int ID_W       = 32;
  localparam int GAP_W      = 32;
  localparam int FACE_W     = 3;
  localparam int NUM_FACES  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TOL_W      = 31;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SELF_MIN_X,
    REG_SELF_MIN_Y,
    REG_SELF_MIN_Z,
    REG_SELF_MAX_X,
    REG_SELF_MAX_Y,
    REG_SELF_MAX_Z,
    REG_EPS,
    REG_MAX_DIST
  } cfg_reg_t;

  // one classified box: which faces touch and the gap of each
  typedef struct packed {
    logic [ID_W-1:0]                  id;
    logic [NUM_FACES-1:0]             mask;
    logic [NUM_FACES-1:0][GAP_W-1:0]  gap;
  } hit_entry_t;

endpackage

// ===== rtl/core/acfd_front.sv =====
// front end: distance prune through a pipelined square root and six face tests
module acfd_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [acfd_pkg::ID_W-1:0]             in_other_id,
  input  logic signed [COORD_WIDTH-1:0]         in_other_min_x,
  input  logic signed [COORD_WIDTH-1:0]         in_other_min_y,
  input  logic signed [COORD_WIDTH-1:0]         in_other_min_z,
  input  logic signed [COORD_WIDTH-1:0]         in_other_max_x,
  input  logic signed [COORD_WIDTH-1:0]         in_other_max_y,
  input  logic signed [COORD_WIDTH-1:0]         in_other_max_z,
  input  logic signed [COORD_WIDTH-1:0]         self_min [3],
  input  logic signed [COORD_WIDTH-1:0]         self_max [3],
  input  logic [acfd_pkg::TOL_W-1:0]            eps,
  input  logic [acfd_pkg::TOL_W-1:0]            max_dist,
  output logic                                  hit_push,
  output acfd_pkg::hit_entry_t                  hit_entry,
  input  logic                                  q_full
);

  localparam int W   = COORD_WIDTH;
  localparam int MW  = W + 2;
  localparam int SQW = 2 * MW;
  localparam int RW  = MW;
  localparam int RMW = RW + 3;
  localparam int NS  = RW + 3;
  localparam int DW  = W + 1;
  localparam int GW  = (DW > acfd_pkg::GAP_W) ? DW : acfd_pkg::GAP_W;
  localparam int PW  = ((RW > acfd_pkg::TOL_W + 1) ? RW : acfd_pkg::TOL_W + 1) + 2;

  logic adv;

  logic                        v_r   [NS];
  logic [acfd_pkg::ID_W-1:0]   id_r  [NS];
  logic signed [W-1:0]         omn_r [NS][3];
  logic signed [W-1:0]         omx_r [NS][3];

  logic [MW-1:0]  mag_r [3][3];
  logic [SQW-1:0] sq_r  [3][3];
  logic [SQW-1:0] rad_r [RW][3];
  logic [RMW-1:0] rem_r [1:RW][3];
  logic [RW-1:0]  root_r [1:RW][3];

  wire [SQW-1:0] rad_nxt  [1:RW][3];
  wire [RMW-1:0] rem_nxt  [1:RW][3];
  wire [RW-1:0]  root_nxt [1:RW][3];

  logic signed [W-1:0] imn [3];
  logic signed [W-1:0] imx [3];
  logic [MW-1:0]       mag_nxt [3][3];

  // vectors are doubled: centre difference, self extent, other extent
  always_comb begin
    logic signed [MW-1:0] vec;
    imn[0] = in_other_min_x; imn[1] = in_other_min_y; imn[2] = in_other_min_z;
    imx[0] = in_other_max_x; imx[1] = in_other_max_y; imx[2] = in_other_max_z;
    for (int k = 0; k < 3; k++) begin
      vec = (MW'(imn[k]) + MW'(imx[k])) - (MW'(self_min[k]) + MW'(self_max[k]));
      mag_nxt[0][k] = vec[MW-1] ? MW'(-vec) : MW'(vec);
      vec = MW'(self_max[k]) - MW'(self_min[k]);
      mag_nxt[1][k] = vec[MW-1] ? MW'(-vec) : MW'(vec);
      vec = MW'(imx[k]) - MW'(imn[k]);
      mag_nxt[2][k] = vec[MW-1] ? MW'(-vec) : MW'(vec);
    end
  end

  // one root bit per stage, restoring digit recurrence
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    for (genvar j = 0; j < 3; j++) begin : g_vec
      logic [RMW-1:0] rem_in;
      logic [RW-1:0]  root_in;
      logic [RMW-1:0] rem_sh;
      logic [RMW-1:0] trial;
      logic           ge;
      if (k == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign rem_in  = rem_r[k][j];
        assign root_in = root_r[k][j];
      end
      assign rem_sh = {rem_in[RMW-3:0], rad_r[k][j][SQW-1 -: 2]};
      assign trial  = {1'b0, root_in, 2'b01};
      assign ge     = rem_sh >= trial;
      assign rem_nxt[k+1][j]  = ge ? rem_sh - trial : rem_sh;
      assign root_nxt[k+1][j] = {root_in[RW-2:0], ge};
      assign rad_nxt[k+1][j]  = rad_r[k][j] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < NS; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id_r[0] <= in_other_id;
      for (int k = 0; k < 3; k++) begin
        omn_r[0][k] <= imn[k];
        omx_r[0][k] <= imx[k];
      end
      for (int s = 1; s < NS; s++) begin
        id_r[s] <= id_r[s-1];
        for (int k = 0; k < 3; k++) begin
          omn_r[s][k] <= omn_r[s-1][k];
          omx_r[s][k] <= omx_r[s-1][k];
        end
      end
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          mag_r[j][k] <= mag_nxt[j][k];
          sq_r[j][k]  <= mag_r[j][k] * mag_r[j][k];
        end
        rad_r[0][j] <= sq_r[j][0] + sq_r[j][1] + sq_r[j][2];
        for (int k = 1; k < RW; k++) rad_r[k][j] <= rad_nxt[k][j];
        for (int k = 1; k <= RW; k++) begin
          rem_r[k][j]  <= rem_nxt[k][j];
          root_r[k][j] <= root_nxt[k][j];
        end
      end
    end
  end

  // last stage: prune compare and face tests against the held box
  logic [PW-1:0]              reach;
  logic                       near;
  logic [acfd_pkg::NUM_FACES-1:0] face_hit;
  logic [acfd_pkg::NUM_FACES-1:0][acfd_pkg::GAP_W-1:0] face_gap;

  assign reach = PW'({max_dist, 1'b0}) + PW'(root_r[RW][1]) + PW'(root_r[RW][2]);
  assign near  = PW'(root_r[RW][0]) <= reach;

  for (genvar f = 0; f < acfd_pkg::NUM_FACES; f++) begin : g_face
    localparam int AX = f / 2;
    localparam int A1 = (AX + 1) % 3;
    localparam int A2 = (AX + 2) % 3;
    logic signed [DW-1:0] d;
    logic [DW-1:0]        am;
    logic [GW-1:0]        gm;
    logic                 meet1, meet2;
    if ((f % 2) == 0) begin : g_upper
      assign d = DW'(self_max[AX]) - DW'(omn_r[NS-1][AX]);
    end else begin : g_lower
      assign d = DW'(self_min[AX]) - DW'(omx_r[NS-1][AX]);
    end
    assign am    = d[DW-1] ? DW'(-d) : DW'(d);
    assign gm    = GW'(am);
    assign meet1 = (self_min[A1] <= omx_r[NS-1][A1]) && (omn_r[NS-1][A1] <= self_max[A1]);
    assign meet2 = (self_min[A2] <= omx_r[NS-1][A2]) && (omn_r[NS-1][A2] <= self_max[A2]);
    assign face_hit[f] = near && (gm <= GW'(eps)) && meet1 && meet2;
    assign face_gap[f] = gm[acfd_pkg::GAP_W-1:0];
  end

  assign hit_entry.id   = id_r[NS-1];
  assign hit_entry.mask = face_hit;
  assign hit_entry.gap  = face_gap;

  // items without a hit fall out of the pipe without touching the queue
  assign hit_push = v_r[NS-1] && (|face_hit);
  assign adv      = !(hit_push && q_full);
  assign in_ready = adv;

endmodule

// ===== rtl/core/acfd_queue.sv =====
// two-entry queue of classified boxes between front and back
module acfd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  acfd_pkg::hit_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 nonempty,
  output acfd_pkg::hit_entry_t head
);

  acfd_pkg::hit_entry_t             mem_r [acfd_pkg::Q_DEPTH];
  logic [acfd_pkg::Q_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [acfd_pkg::Q_PTR_W:0]       count_r, count_nxt;
  logic                             do_push, do_pop;

  assign full     = count_r == (acfd_pkg::Q_PTR_W + 1)'(acfd_pkg::Q_DEPTH);
  assign nonempty = count_r != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

// ===== rtl/core/acfd_back.sv =====
// back end: walks the hit mask of one box and sends one result per face
module acfd_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_nonempty,
  input  acfd_pkg::hit_entry_t              q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [acfd_pkg::ID_W-1:0]         out_hit_id,
  output logic [acfd_pkg::FACE_W-1:0]       out_self_face,
  output logic [acfd_pkg::FACE_W-1:0]       out_other_face,
  output logic [acfd_pkg::GAP_W-1:0]        out_gap,
  output logic                              out_last
);

  acfd_pkg::hit_entry_t           cur_r;
  logic                           cur_v_r;
  logic                           out_v_r;
  logic [acfd_pkg::FACE_W-1:0]    fsel;
  logic [acfd_pkg::NUM_FACES-1:0] rest;
  logic                           emit, cur_done;

  always_comb begin
    fsel = '0;
    for (int i = acfd_pkg::NUM_FACES - 1; i >= 0; i--) begin
      if (cur_r.mask[i]) fsel = acfd_pkg::FACE_W'(i);
    end
  end

  assign rest     = cur_r.mask & ~(acfd_pkg::NUM_FACES'(1) << fsel);
  assign emit     = cur_v_r && (!out_v_r || out_ready);
  assign cur_done = emit && (rest == '0);
  assign q_pop    = q_nonempty && (!cur_v_r || cur_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) cur_v_r <= 1'b1;
      else if (cur_done) cur_v_r <= 1'b0;
      if (emit) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    else if (emit) cur_r.mask <= rest;
    if (emit) begin
      out_hit_id     <= cur_r.id;
      out_self_face  <= fsel;
      out_other_face <= {fsel[acfd_pkg::FACE_W-1:1], ~fsel[0]};
      out_gap        <= cur_r.gap[fsel];
      out_last       <= rest == '0;
    end
  end

  assign out_valid = out_v_r;

endmodule

// ===== rtl/core/aabb_coplanar_face_detector_core.sv =====
// top level of the box face contact detector
// Face contact test of one held box against a stream of other boxes.
// Load the held box, eps and max_dist through the cfg_ write port while
// the block is idle; the configuration registers reset to zero.
// Each input transfer on in_ carries one other box. A box that passes the
// distance prune and touches on some faces yields one out_ transfer per
// touching face, in face order right, left, top, bottom, front, back, with
// out_last high on the final one; a box with no contact yields nothing.
// The front pipeline takes a box every cycle while in_ready is high; its
// depth is set by the square root, one root bit per stage. A result passes
// through the front pipeline, the queue, the back and the output register.
// The back sends one result per cycle while the receiver is ready, and takes
// the next box from the queue as it sends the last result of the current one.
// When the receiver stalls, results wait in the output register, the back
// and a two-entry queue; once the queue is full and a box with hits reaches
// the end of the pipe, in_ready drops until space frees.
// No clearing pass after reset: the block accepts input at once.
module aabb_coplanar_face_detector_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [acfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [acfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [acfd_pkg::ID_W-1:0]           in_other_id,
  input  logic signed [COORD_WIDTH-1:0]       in_other_min_x,
  input  logic signed [COORD_WIDTH-1:0]       in_other_min_y,
  input  logic signed [COORD_WIDTH-1:0]       in_other_min_z,
  input  logic signed [COORD_WIDTH-1:0]       in_other_max_x,
  input  logic signed [COORD_WIDTH-1:0]       in_other_max_y,
  input  logic signed [COORD_WIDTH-1:0]       in_other_max_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [acfd_pkg::ID_W-1:0]           out_hit_id,
  output logic [acfd_pkg::FACE_W-1:0]         out_self_face,
  output logic [acfd_pkg::FACE_W-1:0]         out_other_face,
  output logic [acfd_pkg::GAP_W-1:0]          out_gap,
  output logic                                out_last
);

  logic signed [COORD_WIDTH-1:0] self_min_r [3];
  logic signed [COORD_WIDTH-1:0] self_max_r [3];
  logic [acfd_pkg::TOL_W-1:0]    eps_r, max_dist_r;
  logic signed [COORD_WIDTH-1:0] coord_wdata;

  // narrow coordinates keep the low bits, wide ones are zero filled
  if (COORD_WIDTH <= acfd_pkg::CFG_DATA_W) begin : g_cfg_narrow
    assign coord_wdata = cfg_wdata[COORD_WIDTH-1:0];
  end else begin : g_cfg_wide
    assign coord_wdata = COORD_WIDTH'(cfg_wdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        self_min_r[k] <= '0;
        self_max_r[k] <= '0;
      end
      eps_r      <= '0;
      max_dist_r <= '0;
    end else if (cfg_we) begin
      case (acfd_pkg::cfg_reg_t'(cfg_index))
        acfd_pkg::REG_SELF_MIN_X: self_min_r[0] <= coord_wdata;
        acfd_pkg::REG_SELF_MIN_Y: self_min_r[1] <= coord_wdata;
        acfd_pkg::REG_SELF_MIN_Z: self_min_r[2] <= coord_wdata;
        acfd_pkg::REG_SELF_MAX_X: self_max_r[0] <= coord_wdata;
        acfd_pkg::REG_SELF_MAX_Y: self_max_r[1] <= coord_wdata;
        acfd_pkg::REG_SELF_MAX_Z: self_max_r[2] <= coord_wdata;
        acfd_pkg::REG_EPS:        eps_r <= cfg_wdata[acfd_pkg::TOL_W-1:0];
        acfd_pkg::REG_MAX_DIST:   max_dist_r <= cfg_wdata[acfd_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic                 hit_push, q_full, q_pop, q_nonempty;
  acfd_pkg::hit_entry_t hit_entry, q_head;

  acfd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_other_id    (in_other_id),
    .in_other_min_x (in_other_min_x),
    .in_other_min_y (in_other_min_y),
    .in_other_min_z (in_other_min_z),
    .in_other_max_x (in_other_max_x),
    .in_other_max_y (in_other_max_y),
    .in_other_max_z (in_other_max_z),
    .self_min       (self_min_r),
    .self_max       (self_max_r),
    .eps            (eps_r),
    .max_dist       (max_dist_r),
    .hit_push       (hit_push),
    .hit_entry      (hit_entry),
    .q_full         (q_full)
  );

  acfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (hit_push),
    .push_entry (hit_entry),
    .full       (q_full),
    .pop        (q_pop),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  acfd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit_id     (out_hit_id),
    .out_self_face  (out_self_face),
    .out_other_face (out_other_face),
    .out_gap        (out_gap),
    .out_last       (out_last)
  );

  // a box with hits facing a full queue must hold the whole front
  a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_push && q_full) |-> !in_ready)
    else $error("front advanced while queue full");

  // hits of one box leave back to back
  a_hits_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("gap inside the hits of one box");

  // the back only takes from a queue that holds something
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nonempty)
    else $error("pop from empty queue");

endmodule
